// ----- hdl/tsp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_pkg
// Shared types and codes of the triggered sample player: request kinds,
// register indexes and the configuration record.
// ---------------------------------------------------------------------------
package tsp_pkg;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // register indexes on the csr port
   localparam logic REG_LOOP_MODE     = 1'b0;
   localparam logic REG_SAMPLE_LENGTH = 1'b1;

   localparam int ADDR_BITS   = 16;
   localparam int Q15_BITS    = 16;
   localparam int TRIG_BITS   = 4;
   localparam int LENGTH_BITS = 17;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [ADDR_BITS-1:0]    addr_type;
   typedef logic signed [Q15_BITS-1:0] q15_type;
   typedef logic [TRIG_BITS-1:0]    trig_type;
   typedef logic [LENGTH_BITS-1:0]  length_type;

   // configuration seen by the playback logic
   typedef struct packed {
      logic       loop_mode;
      length_type sample_length;
   } cfg_type;

endpackage

// ----- hdl/tsp_req_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_req_if
// Request channel: load words and output ticks with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tsp_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   tsp_pkg::addr_type  sample_addr;
   tsp_pkg::q15_type   sample_value;
   tsp_pkg::trig_type  trigger_count;
   logic               restart;

   modport source (output valid, req_type, sample_addr, sample_value,
                   trigger_count, restart, input ready);
   modport sink   (input valid, req_type, sample_addr, sample_value,
                   trigger_count, restart, output ready);
endinterface

// ----- hdl/tsp_rsp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_rsp_if
// Response channel: one output sample word per tick.
// ---------------------------------------------------------------------------
interface tsp_rsp_if;
   logic             valid;
   logic             ready;
   tsp_pkg::q15_type sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

// ----- hdl/tsp_csr.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsp_csr
// APB register file holding loop mode and sample length.
// ---------------------------------------------------------------------------
module tsp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tsp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tsp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready,
   output tsp_pkg::cfg_type                   cfg
);

   logic                 loop_mode_ff;
   tsp_pkg::length_type  sample_length_ff;
   logic                 reg_index;
   logic                 wr_en;

   assign reg_index = paddr[2];
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff     <= 1'b0;
         sample_length_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_index)
            tsp_pkg::REG_LOOP_MODE:     loop_mode_ff     <= pwdata[0];
            tsp_pkg::REG_SAMPLE_LENGTH:
               sample_length_ff <= pwdata[tsp_pkg::LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         tsp_pkg::REG_LOOP_MODE:     prdata[0] = loop_mode_ff;
         tsp_pkg::REG_SAMPLE_LENGTH:
            prdata[tsp_pkg::LENGTH_BITS-1:0] = sample_length_ff;
         default: ;
      endcase
   end

   assign cfg.loop_mode     = loop_mode_ff;
   assign cfg.sample_length = sample_length_ff;

endmodule

// ----- hdl/triggered_sample_player_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// triggered_sample_player_core
// Plays a stored mono sample in one-shot or loop mode, one word per tick.
// ---------------------------------------------------------------------------
// The block takes one request per cycle, loads and ticks alike, with no
// bubbles while the output side is not held; a held output word stalls
// requests once a tick waits in the read stage. A tick's output word is
// registered in the store read register, then in the output register.
// The playhead and running flag are kept in registers and updated
// in the cycle a request is taken, so the next request sees them at once.
// The sample store is a single memory with one write port (loads) and one
// read port (ticks); it powers up undefined and needs no clearing pass.
// ---------------------------------------------------------------------------
module triggered_sample_player_core #(
   parameter int DEPTH       = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   tsp_req_if.sink                            req_bus,
   tsp_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tsp_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tsp_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tsp_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int QB = tsp_pkg::Q15_BITS;
   localparam int LB = tsp_pkg::LENGTH_BITS;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(DEPTH));

   // reduce a load address into the store range: reciprocal estimate of
   // the quotient, then one correcting subtract
   function automatic logic [AW-1:0] store_index(input tsp_pkg::addr_type a);
      logic [tsp_pkg::ADDR_BITS+31:0] prod;
      logic [tsp_pkg::ADDR_BITS-1:0]  quot;
      logic [40:0]                    rem;
      prod = (tsp_pkg::ADDR_BITS+32)'(a) * (tsp_pkg::ADDR_BITS+32)'(RECIP);
      quot = prod[tsp_pkg::ADDR_BITS+31:32];
      rem  = 41'(a) - 41'(quot) * 41'(DEPTH);
      if (rem >= 41'(DEPTH)) rem = rem - 41'(DEPTH);
      return rem[AW-1:0];
   endfunction

   tsp_pkg::cfg_type cfg;

   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sample store and playback state
   logic [SAMPLE_BITS-1:0] sample_store_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [LB-1:0]          pos_ff, pos_in;
   logic [AW-1:0]          pidx_ff, pidx_in;
   logic                   playing_ff, playing_in;

   // read and output stages
   logic            p1_valid_ff, p1_valid_in;
   logic            p1_gate_ff;
   logic            out_valid_ff, out_valid_in;
   tsp_pkg::q15_type out_data_ff;

   logic            accept, is_tick, is_load, p1_move, out_take;
   logic            gate;
   logic [LB-1:0]   pos_r, pos_t, pos_next;
   logic [AW-1:0]   pidx_r, pidx_t, pidx_next;
   logic            play_r, play_t, active, at_end, trig_any;
   logic [SAMPLE_BITS-1:0] wr_data;
   tsp_pkg::q15_type rd_word;

   // handshake
   assign out_take    = out_valid_ff & rsp_bus.ready;
   assign p1_move     = p1_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~p1_valid_ff | p1_move;
   assign accept      = req_bus.valid & req_bus.ready;
   assign is_tick     = accept & (req_bus.req_type == tsp_pkg::REQ_TICK);
   assign is_load     = accept & (req_bus.req_type == tsp_pkg::REQ_LOAD);

   // word width adaptation between Q1.15 and store width
   generate
      if (SAMPLE_BITS >= QB) begin : g_wide
         assign wr_data = SAMPLE_BITS'(req_bus.sample_value);
         assign rd_word = rd_data_ff[QB-1:0];
      end else begin : g_narrow
         assign wr_data = req_bus.sample_value[SAMPLE_BITS-1:0];
         assign rd_word = QB'(rd_data_ff);
      end
   endgenerate

   // playhead update: loads rewind; ticks restart, then trigger, then advance
   always_comb begin
      trig_any = (req_bus.trigger_count != '0);
      pos_r    = req_bus.restart ? '0 : pos_ff;
      pidx_r   = req_bus.restart ? '0 : pidx_ff;
      play_r   = req_bus.restart ? 1'b0 : playing_ff;
      active   = (cfg.sample_length != '0) & (play_r | trig_any);

      pos_t  = pos_r;
      pidx_t = pidx_r;
      play_t = play_r;
      if (trig_any) begin
         pos_t  = '0;
         pidx_t = '0;
         play_t = cfg.loop_mode ? (play_r ^ req_bus.trigger_count[0]) : 1'b1;
      end
      gate = active & play_t;

      pos_next  = pos_t + LB'(1);
      pidx_next = (pidx_t == AW'(DEPTH - 1)) ? '0 : pidx_t + AW'(1);
      at_end    = (pos_next >= cfg.sample_length);

      pos_in     = pos_ff;
      pidx_in    = pidx_ff;
      playing_in = playing_ff;
      if (is_load) begin
         pos_in     = '0;
         pidx_in    = '0;
         playing_in = 1'b0;
      end else if (is_tick) begin
         if (!active) begin
            pos_in     = pos_r;
            pidx_in    = pidx_r;
            playing_in = play_r;
         end else if (cfg.loop_mode) begin
            pos_in     = at_end ? '0 : pos_next;
            pidx_in    = at_end ? '0 : pidx_next;
            playing_in = play_t;
         end else if (at_end) begin
            // one shot reached the end: park on the length
            pos_in     = cfg.sample_length;
            pidx_in    = '0;
            playing_in = 1'b0;
         end else begin
            pos_in     = pos_next;
            pidx_in    = pidx_next;
            playing_in = play_t;
         end
      end
   end

   // stage valids
   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (p1_move) p1_valid_in = 1'b0;
      if (is_tick) p1_valid_in = 1'b1;
      out_valid_in = out_valid_ff;
      if (out_take) out_valid_in = 1'b0;
      if (p1_move)  out_valid_in = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pidx_ff      <= '0;
         playing_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pidx_ff      <= pidx_in;
         playing_ff   <= playing_in;
         p1_valid_ff  <= p1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (is_load) sample_store_ff[store_index(req_bus.sample_addr)] <= wr_data;
      if (is_tick) begin
         rd_data_ff <= sample_store_ff[pidx_t];
         p1_gate_ff <= gate;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (p1_move) out_data_ff <= p1_gate_ff ? rd_word : '0;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sample_out = out_data_ff;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for triggered_sample_player_core.
// A directed table walks empty sample, one-shot stop and restart, loop
// toggling, wrap and a playhead left past a lowered length. Random load and
// tick bursts follow under several register settings. Each tick's output
// word is predicted in the bench and compared in order with the block's
// output. Ticks that would play a never-loaded word are turned into silent
// restarts before they are sent.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 4;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   // one word on the request channel
   typedef struct packed {
      logic              req_type;
      tsp_pkg::addr_type addr;
      tsp_pkg::q15_type  value;
      tsp_pkg::trig_type trig;
      logic              restart;
   } player_word_type;

   typedef struct {
      row_kind_type     kind;
      player_word_type  word;
      logic             has_exp;
      tsp_pkg::q15_type exp;
      logic             reg_index;
      logic [31:0]      reg_value;
   } stim_row_type;

   // what one tick does to the playback state
   typedef struct packed {
      logic                reads;
      tsp_pkg::addr_type   rd_addr;
      tsp_pkg::q15_type    word;
      logic                running;
      tsp_pkg::length_type playhead;
   } tick_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [tsp_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [tsp_pkg::CSR_DATA_BITS-1:0] pwdata, prdata;

   tsp_req_if req_bus ();
   tsp_rsp_if rsp_bus ();

   triggered_sample_player_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   tsp_pkg::q15_type    sample_mem [0:65535];
   bit                  loaded     [0:65535];
   tsp_pkg::length_type playhead;
   logic                running;
   logic                cfg_loop;
   tsp_pkg::length_type cfg_length;

   tsp_pkg::q15_type pending_samples [$];
   int unsigned      mismatches;
   tsp_pkg::q15_type oldest;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned stall_requests;
   int unsigned stalls_served;
   int unsigned hold_left;
   int unsigned quiet_cycles;

   stim_row_type directed_rows [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic stim_row_type load_row(tsp_pkg::addr_type addr,
                                             tsp_pkg::q15_type value,
                                             tsp_pkg::trig_type trig,
                                             logic restart);
      stim_row_type r;
      r = '{kind: ROW_WORD, word: '{tsp_pkg::REQ_LOAD, addr, value, trig, restart},
            has_exp: 1'b0, exp: '0, reg_index: 1'b0, reg_value: '0};
      return r;
   endfunction

   function automatic stim_row_type tick_row(tsp_pkg::trig_type trig, logic restart,
                                             logic has_exp, tsp_pkg::q15_type exp);
      stim_row_type r;
      r = '{kind: ROW_WORD,
            word: '{tsp_pkg::REQ_TICK, 16'h5A5A, 16'sh0F0F, trig, restart},
            has_exp: has_exp, exp: exp, reg_index: 1'b0, reg_value: '0};
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic index, logic [31:0] value);
      stim_row_type r;
      r = '{kind: ROW_CSR, word: '0, has_exp: 1'b0, exp: '0,
            reg_index: index, reg_value: value};
      return r;
   endfunction

   function automatic player_word_type random_word(logic kind);
      player_word_type w;
      w.req_type = kind;
      w.value    = tsp_pkg::q15_type'($urandom);
      w.restart  = 1'b0;
      if (kind == tsp_pkg::REQ_LOAD) begin
         // mostly the low region that playback reaches, sometimes anywhere
         w.addr    = ($urandom_range(3) == 0) ? tsp_pkg::addr_type'($urandom)
                                              : tsp_pkg::addr_type'($urandom_range(63));
         w.trig    = tsp_pkg::trig_type'($urandom);
         w.restart = 1'($urandom_range(1));
      end else begin
         w.addr = tsp_pkg::addr_type'($urandom);
         w.trig = ($urandom_range(9) < 7) ? '0
                                          : tsp_pkg::trig_type'($urandom_range(15, 1));
         if ($urandom_range(19) == 0)
            w.restart = 1'b1;
      end
      return w;
   endfunction

   // playback step for one tick, without committing it
   function automatic tick_outcome_type play_tick(tsp_pkg::trig_type trig, logic restart);
      tick_outcome_type o;
      logic [tsp_pkg::LENGTH_BITS:0] nxt;
      o          = '0;
      o.running  = running;
      o.playhead = playhead;
      if (restart) begin
         o.playhead = '0;
         o.running  = 1'b0;
      end
      if (cfg_length != '0 && (o.running || trig != '0)) begin
         if (trig != '0) begin
            o.playhead = '0;
            o.running  = cfg_loop ? (o.running ^ trig[0]) : 1'b1;
         end
         if (o.running) begin
            o.reads   = 1'b1;
            o.rd_addr = o.playhead[tsp_pkg::ADDR_BITS-1:0];
            o.word    = sample_mem[o.rd_addr];
         end
         nxt = {1'b0, o.playhead} + 1'b1;
         if (cfg_loop) begin
            o.playhead = (nxt >= {1'b0, cfg_length}) ? '0
                                                     : nxt[tsp_pkg::LENGTH_BITS-1:0];
         end else if (nxt >= {1'b0, cfg_length}) begin
            o.running  = 1'b0;
            o.playhead = cfg_length;
         end else begin
            o.playhead = nxt[tsp_pkg::LENGTH_BITS-1:0];
         end
      end
      return o;
   endfunction

   // send one word, then update the predictor once it is taken
   task automatic send_word(player_word_type w, logic has_exp, tsp_pkg::q15_type exp);
      tick_outcome_type o;
      if (w.req_type == tsp_pkg::REQ_TICK) begin
         o = play_tick(w.trig, w.restart);
         // never play a word that was not loaded: make it a silent restart
         if (o.reads && !loaded[o.rd_addr]) begin
            w.trig    = '0;
            w.restart = 1'b1;
            o         = play_tick(w.trig, w.restart);
         end
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= w.req_type;
      req_bus.sample_addr   <= w.addr;
      req_bus.sample_value  <= w.value;
      req_bus.trigger_count <= w.trig;
      req_bus.restart       <= w.restart;
      do @(posedge clock); while (!req_bus.ready);
      if (w.req_type == tsp_pkg::REQ_LOAD) begin
         sample_mem[w.addr] = w.value;
         loaded[w.addr]     = 1'b1;
         playhead           = '0;
         running            = 1'b0;
      end else begin
         playhead = o.playhead;
         running  = o.running;
         pending_samples.push_back(has_exp ? exp : o.word);
      end
   endtask

   // stop offering words and let the block run dry
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic index, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (index == tsp_pkg::REG_LOOP_MODE)
         cfg_loop = value[0];
      else
         cfg_length = value[tsp_pkg::LENGTH_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic flag_mismatch(string what, tsp_pkg::q15_type want,
                                tsp_pkg::q15_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch (%s): expected %h, got %h", $realtime, what, want, got);
   endtask

   // receiver: random stalls, plus a long hold-off when asked for
   always @(posedge clock) begin
      if (stall_requests != stalls_served) begin
         stalls_served = stall_requests;
         hold_left     = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // output word checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            flag_mismatch("unexpected word", '0, rsp_bus.sample_out);
         end else begin
            oldest = pending_samples.pop_front();
            if (rsp_bus.sample_out !== oldest)
               flag_mismatch("sample_out", oldest, rsp_bus.sample_out);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (psel && penable) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL triggered_sample_player_core");
         $finish;
      end
   end

   initial begin
      int unsigned send_pcts [3];
      int unsigned recv_pcts [3];
      logic [31:0] lengths [12];
      int unsigned items;
      int unsigned n;
      send_pcts = '{13, 83, 0};
      recv_pcts = '{83, 13, 0};
      lengths   = '{1, 65536, 0, 17, 5, 65535, 2, 40, 9, 64, 3, 23};

      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = tsp_pkg::REQ_LOAD;
      req_bus.sample_addr   = '0;
      req_bus.sample_value  = '0;
      req_bus.trigger_count = '0;
      req_bus.restart       = 1'b0;
      rsp_bus.ready         = 1'b0;
      playhead              = '0;
      running               = 1'b0;
      cfg_loop              = 1'b0;
      cfg_length            = '0;
      mismatches            = 0;
      stall_requests        = 0;
      stalls_served         = 0;
      hold_left             = 0;
      quiet_cycles          = 0;
      send_idle_pct         = send_pcts[0];
      recv_idle_pct         = recv_pcts[0];

      directed_rows = '{
         // empty sample after reset, trigger and restart do nothing audible
         tick_row(4'hF, 1'b0, 1'b1, 16'sh0000),
         tick_row(4'h0, 1'b1, 1'b1, 16'sh0000),
         load_row(16'h0000, 16'sh8000, 4'h0, 1'b0),
         // tick fields on a load are ignored
         load_row(16'h0001, 16'sh7FFF, 4'hF, 1'b1),
         load_row(16'h0002, 16'sh0001, 4'h0, 1'b0),
         load_row(16'hFFFF, 16'shFFFF, 4'h0, 1'b0),
         load_row(16'h0003, 16'sh1234, 4'h0, 1'b0),
         csr_row(tsp_pkg::REG_SAMPLE_LENGTH, 32'd3),
         // one shot: silent until triggered, stops at the end
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0000),
         tick_row(4'h1, 1'b0, 1'b1, 16'sh8000),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh7FFF),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0001),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0000),
         // restart then trigger in the same tick
         tick_row(4'hF, 1'b1, 1'b1, 16'sh8000),
         // length lowered below the playhead while playing
         csr_row(tsp_pkg::REG_SAMPLE_LENGTH, 32'd1),
         tick_row(4'h0, 1'b0, 1'b0, 16'sh0000),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0000),
         // loop mode: odd count toggles, even count only rewinds
         csr_row(tsp_pkg::REG_LOOP_MODE, 32'd1),
         csr_row(tsp_pkg::REG_SAMPLE_LENGTH, 32'd3),
         tick_row(4'h1, 1'b0, 1'b1, 16'sh8000),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh7FFF),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0001),
         tick_row(4'h0, 1'b0, 1'b0, 16'sh0000),
         tick_row(4'h2, 1'b0, 1'b0, 16'sh0000),
         tick_row(4'h3, 1'b0, 1'b1, 16'sh0000),
         tick_row(4'h0, 1'b0, 1'b1, 16'sh0000),
         tick_row(4'h1, 1'b0, 1'b0, 16'sh0000),
         tick_row(4'h0, 1'b0, 1'b0, 16'sh0000),
         // loop with the playhead past a lowered length wraps
         csr_row(tsp_pkg::REG_SAMPLE_LENGTH, 32'd1),
         tick_row(4'h0, 1'b0, 1'b0, 16'sh0000),
         csr_row(tsp_pkg::REG_SAMPLE_LENGTH, 32'd65536),
         tick_row(4'h0, 1'b0, 1'b0, 16'sh0000),
         tick_row(4'h1, 1'b0, 1'b1, 16'sh0000),
         tick_row(4'h0, 1'b1, 1'b1, 16'sh0000)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain();
            csr_write(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].has_exp,
                      directed_rows[i].exp);
         end
      end

      // random load and tick bursts under changing settings and idling
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = send_pcts[p];
         recv_idle_pct = recv_pcts[p];
         for (int s = 0; s < 4; s++) begin
            drain();
            csr_write(tsp_pkg::REG_LOOP_MODE, 32'($urandom_range(1)));
            csr_write(tsp_pkg::REG_SAMPLE_LENGTH, lengths[p*4 + s]);
            if (p == 2 && s == 0)
               stall_requests++;
            items = 0;
            while (items < 44) begin
               n = $urandom_range(4);
               repeat (n) begin
                  send_word(random_word(tsp_pkg::REQ_LOAD), 1'b0, '0);
                  items++;
               end
               n = $urandom_range(24, 1);
               repeat (n) begin
                  send_word(random_word(tsp_pkg::REQ_TICK), 1'b0, '0);
                  items++;
               end
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_samples.size() == 0)
         $display("PASS triggered_sample_player_core");
      else
         $display("FAIL triggered_sample_player_core");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/tsp_pkg.sv
hdl/tsp_req_if.sv
hdl/tsp_rsp_if.sv
hdl/tsp_csr.sv
hdl/triggered_sample_player_core.sv
tb/tb_top.sv
